### sv/kqs_pkg.sv
// Shared constants, types and helpers for the quickselect rank selector.
// Used by kqs_engine and kth_smallest_quickselect; depends on nothing else.
package kqs_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int SAMPLE_WIDTH = 32;
    localparam int RANK_W       = 9;
    // Element index runs 1..MAX_ELEMENTS, so it must hold MAX_ELEMENTS itself
    localparam int IDX_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int IN_DATA_W    = ((SAMPLE_WIDTH + RANK_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]               t_idx;
    typedef logic [ADDR_W-1:0]              t_addr;
    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    // Sample write from the load side into the element store
    typedef struct packed {
        logic    we;
        t_idx    idx;
        t_sample data;
    } t_load;

    // Selection launch
    typedef struct packed {
        logic valid;
        t_idx rank;
        t_idx count;
    } t_start;

    // Selection finished
    typedef struct packed {
        logic    valid;
        t_sample value;
    } t_done;

    // Map a 1-based element index onto its store address
    function automatic t_addr mem_addr(input t_idx idx);
        t_idx tmp;
        tmp = idx - t_idx'(1);
        return tmp[ADDR_W-1:0];
    endfunction

endpackage

### sv/kqs_engine.sv
// Element store plus quickselect sequencer (median-of-three, Hoare partition).
// One compare unit, one store write port and one store read port shared by every step; uses kqs_pkg.
module kqs_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kqs_pkg::t_load i_load,
    input  kqs_pkg::t_start i_start,
    output kqs_pkg::t_done o_done
);

    typedef enum logic [4:0] {
        E_IDLE, E_TOP,
        E_SW_RA, E_SW_RB, E_SW_WA, E_SW_WB,
        E_P1, E_P2, E_P3, E_P4, E_P5,
        E_ISTEP, E_ICHK, E_JSTEP, E_JCHK, E_CMP,
        E_F1, E_F2, E_F3,
        E_RES1, E_RES2
    } t_estate;

    // Element store
    kqs_pkg::t_sample r_mem [kqs_pkg::MAX_ELEMENTS];
    kqs_pkg::t_sample r_rd_data;

    // Sequencer state
    t_estate          r_state, n_state;
    t_estate          r_ret,   n_ret;
    kqs_pkg::t_idx    r_l, n_l, r_r, n_r, r_i, n_i, r_j, n_j;
    kqs_pkg::t_idx    r_x, n_x, r_y, n_y, r_rank, n_rank;
    logic             r_cond, n_cond;
    kqs_pkg::t_sample r_a, n_a, r_pivot, n_pivot;
    kqs_pkg::t_done   r_done, n_done;

    // Store port controls
    logic             w_we;
    kqs_pkg::t_idx    w_widx, w_ridx;
    kqs_pkg::t_sample w_wdata;

    kqs_pkg::t_idx    w_l1, w_i1, w_jm1;
    logic [kqs_pkg::IDX_W:0] w_sum;
    kqs_pkg::t_sample w_cmp_a, w_cmp_b;
    logic             w_gt;

    assign w_l1  = r_l + kqs_pkg::t_idx'(1);
    assign w_i1  = r_i + kqs_pkg::t_idx'(1);
    assign w_jm1 = r_j - kqs_pkg::t_idx'(1);
    assign w_sum = {1'b0, r_l} + {1'b0, r_r};

    // Steer the operands of the shared compare unit by sequencer state
    always_comb begin
        case (r_state)
            E_ICHK: begin
                w_cmp_a = r_pivot;
                w_cmp_b = r_rd_data;
            end
            E_JCHK: begin
                w_cmp_a = r_rd_data;
                w_cmp_b = r_pivot;
            end
            default: begin
                w_cmp_a = r_a;
                w_cmp_b = r_rd_data;
            end
        endcase
    end

    // Shared compare unit
    assign w_gt  = (w_cmp_a > w_cmp_b);

    // Sequence the selection one store access per cycle
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_l     = r_l;
        n_r     = r_r;
        n_i     = r_i;
        n_j     = r_j;
        n_x     = r_x;
        n_y     = r_y;
        n_rank  = r_rank;
        n_cond  = r_cond;
        n_a     = r_a;
        n_pivot = r_pivot;
        n_done  = '{valid: 1'b0, value: r_done.value};
        w_we    = i_load.we;
        w_widx  = i_load.idx;
        w_wdata = i_load.data;
        w_ridx  = r_x;
        case (r_state)
            E_IDLE: begin
                if (i_start.valid) begin
                    n_l     = kqs_pkg::t_idx'(1);
                    n_r     = i_start.count;
                    n_rank  = i_start.rank;
                    n_state = E_TOP;
                end
            end
            E_TOP: begin
                if (r_r <= w_l1) begin
                    if (r_r == w_l1) begin
                        n_x     = r_l;
                        n_y     = r_r;
                        n_cond  = 1'b1;
                        n_ret   = E_RES1;
                        n_state = E_SW_RA;
                    end else begin
                        n_state = E_RES1;
                    end
                end else begin
                    // Move the middle element next to the left bound
                    n_x     = w_sum[kqs_pkg::IDX_W:1];
                    n_y     = w_l1;
                    n_cond  = 1'b0;
                    n_ret   = E_P1;
                    n_state = E_SW_RA;
                end
            end
            // Swap subroutine, optionally only when store[x] > store[y]
            E_SW_RA: begin
                w_ridx  = r_x;
                n_state = E_SW_RB;
            end
            E_SW_RB: begin
                n_a     = r_rd_data;
                w_ridx  = r_y;
                n_state = E_SW_WA;
            end
            E_SW_WA: begin
                if (r_cond && !w_gt) begin
                    n_state = r_ret;
                end else begin
                    w_we    = 1'b1;
                    w_widx  = r_x;
                    w_wdata = r_rd_data;
                    n_state = E_SW_WB;
                end
            end
            E_SW_WB: begin
                w_we    = 1'b1;
                w_widx  = r_y;
                w_wdata = r_a;
                n_state = r_ret;
            end
            // Order left, left+1 and right around the median
            E_P1: begin
                n_x     = r_l;
                n_y     = r_r;
                n_cond  = 1'b1;
                n_ret   = E_P2;
                n_state = E_SW_RA;
            end
            E_P2: begin
                n_x     = w_l1;
                n_y     = r_r;
                n_cond  = 1'b1;
                n_ret   = E_P3;
                n_state = E_SW_RA;
            end
            E_P3: begin
                n_x     = r_l;
                n_y     = w_l1;
                n_cond  = 1'b1;
                n_ret   = E_P4;
                n_state = E_SW_RA;
            end
            E_P4: begin
                n_i     = w_l1;
                n_j     = r_r;
                w_ridx  = w_l1;
                n_state = E_P5;
            end
            E_P5: begin
                n_pivot = r_rd_data;
                n_state = E_ISTEP;
            end
            // Advance i past elements below the pivot
            E_ISTEP: begin
                n_i = w_i1;
                if (w_i1 < r_r) begin
                    w_ridx  = w_i1;
                    n_state = E_ICHK;
                end else begin
                    n_state = E_JSTEP;
                end
            end
            E_ICHK: begin
                n_state = w_gt ? E_ISTEP : E_JSTEP;
            end
            // Retreat j past elements above the pivot
            E_JSTEP: begin
                n_j = w_jm1;
                if (w_jm1 > r_l) begin
                    w_ridx  = w_jm1;
                    n_state = E_JCHK;
                end else begin
                    n_state = E_CMP;
                end
            end
            E_JCHK: begin
                n_state = w_gt ? E_JSTEP : E_CMP;
            end
            E_CMP: begin
                if (r_j < r_i) begin
                    n_state = E_F1;
                end else begin
                    n_x     = r_i;
                    n_y     = r_j;
                    n_cond  = 1'b0;
                    n_ret   = E_ISTEP;
                    n_state = E_SW_RA;
                end
            end
            // Drop the pivot into its final place, then narrow the bounds
            E_F1: begin
                w_ridx  = r_j;
                n_state = E_F2;
            end
            E_F2: begin
                w_we    = 1'b1;
                w_widx  = w_l1;
                w_wdata = r_rd_data;
                n_state = E_F3;
            end
            E_F3: begin
                w_we    = 1'b1;
                w_widx  = r_j;
                w_wdata = r_pivot;
                if (r_j >= r_rank) n_r = w_jm1;
                if (r_j <= r_rank) n_l = r_i;
                n_state = E_TOP;
            end
            E_RES1: begin
                w_ridx  = r_rank;
                n_state = E_RES2;
            end
            E_RES2: begin
                n_done  = '{valid: 1'b1, value: r_rd_data};
                n_state = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase
    end

    // Store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[kqs_pkg::mem_addr(w_widx)] <= w_wdata;
        r_rd_data <= r_mem[kqs_pkg::mem_addr(w_ridx)];
    end

    // Hold sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= E_IDLE;
            r_done.valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_done.valid <= n_done.valid;
        end
        r_ret        <= n_ret;
        r_l          <= n_l;
        r_r          <= n_r;
        r_i          <= n_i;
        r_j          <= n_j;
        r_x          <= n_x;
        r_y          <= n_y;
        r_rank       <= n_rank;
        r_cond       <= n_cond;
        r_a          <= n_a;
        r_pivot      <= n_pivot;
        r_done.value <= n_done.value;
    end

    assign o_done = r_done;

endmodule

### sv/kth_smallest_quickselect.sv
// Rank selector: loads a signed sample set, then returns its rank-th smallest element.
// Loading accepts one sample per cycle; after the last sample the input stalls while
// the quickselect engine works. Rank error results skip the engine and pass through the
// hold state into the output register; a result then waits in the output register.
// Synchronous active-low reset clears the count, sequencers and valids.
module kth_smallest_quickselect (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [kqs_pkg::IN_DATA_W-1:0]    i_s_tdata,  // sample [31:0], rank [40:32]
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [kqs_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // selected [31:0]
    output logic                             o_m_tuser   // rank_error [0]
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} t_state;

    t_state           r_state, n_state;
    kqs_pkg::t_idx    r_count, n_count;
    kqs_pkg::t_sample r_res, n_res;
    logic             r_res_err, n_res_err;
    logic             r_m_valid, n_m_valid;
    kqs_pkg::t_sample r_m_data, n_m_data;
    logic             r_m_err, n_m_err;

    kqs_pkg::t_load   w_load;
    kqs_pkg::t_start  w_start;
    kqs_pkg::t_done   w_done;

    logic                        w_acc;
    kqs_pkg::t_sample            w_sample;
    logic [kqs_pkg::RANK_W-1:0]  w_rank_in;
    kqs_pkg::t_idx               w_rank;
    kqs_pkg::t_idx               w_cnt_new;
    logic                        w_room;

    assign w_acc     = i_s_tvalid && o_s_tready;
    assign w_sample  = i_s_tdata[kqs_pkg::SAMPLE_WIDTH-1:0];
    assign w_rank_in = i_s_tdata[kqs_pkg::SAMPLE_WIDTH +: kqs_pkg::RANK_W];
    assign w_rank    = kqs_pkg::t_idx'(w_rank_in);
    assign w_room    = (r_count < kqs_pkg::t_idx'(kqs_pkg::MAX_ELEMENTS));
    assign w_cnt_new = w_room ? (r_count + kqs_pkg::t_idx'(1)) : r_count;

    kqs_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_start (w_start),
        .o_done  (w_done)
    );

    // Load samples, launch the selection and stage the result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_res     = r_res;
        n_res_err = r_res_err;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_err   = r_m_err;
        w_load    = '{we: 1'b0, idx: w_cnt_new, data: w_sample};
        w_start   = '{valid: 1'b0, rank: w_rank, count: w_cnt_new};

        if (r_m_valid && i_m_tready) n_m_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    // Drop samples once the store is full
                    w_load.we = w_room;
                    n_count   = w_cnt_new;
                    if (i_s_tlast) begin
                        n_count = '0;
                        if (w_rank == '0 || w_rank > w_cnt_new) begin
                            n_res     = '0;
                            n_res_err = 1'b1;
                            n_state   = S_HOLD;
                        end else begin
                            w_start.valid = 1'b1;
                            n_state       = S_RUN;
                        end
                    end
                end
            end
            S_RUN: begin
                if (w_done.valid) begin
                    n_res     = w_done.value;
                    n_res_err = 1'b0;
                    n_state   = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res;
                    n_m_err   = r_res_err;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, count and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_res     <= n_res;
        r_res_err <= n_res_err;
        r_m_data  <= n_m_data;
        r_m_err   <= n_m_err;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = kqs_pkg::OUT_DATA_W'(r_m_data);
    assign o_m_tuser  = r_m_err;

    // A closing sample always stalls the input in the following cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_tlast) |=> !o_s_tready)
        else $error("input still ready after the closing sample");

    // The engine finishes only while a selection is running
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done.valid |-> (r_state == S_RUN))
        else $error("engine finished outside a running selection");

    // An error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("rank error result with nonzero value");

    // Loading a result into the output register ends the hold
    a_hold_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && !r_m_valid) |=> (r_state == S_IDLE && o_m_tvalid))
        else $error("held result not moved to the output");

endmodule
